// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define HCBD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define HCBD_ASSERT(label, clk, rst_n, prop)
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/hcbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int HEX_BITS        = 4;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_EXT,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_DONE,
        KIND_ERR
    } t_kind;

    // one raw body byte with its restart flag
    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } t_item;

    // parser result, valid low when the byte gives nothing
    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] data;
    } t_result;

    typedef struct packed {
        logic                ok;
        logic [HEX_BITS-1:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = '0;
        if (c >= "0" && c <= "9") begin
            h.val = 4'(c - 8'("0"));
        end else if (c >= "a" && c <= "f") begin
            h.val = 4'(c - 8'("a") + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            h.val = 4'(c - 8'("A") + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/http_chunked_body_decoder.sv =====
// http chunked body decoder
// input channel: i_valid / o_ready carry one raw body byte (i_in_byte) per
// transaction; i_body_start marks the first byte of a new body and restarts
// the parser, that byte being parsed as the start of a size line
// output channel: o_valid / i_ready carry at most one result per input byte;
// o_kind is payload byte, body complete or framing error, o_data_byte holds
// the payload byte for payload results and zero otherwise
// size lines, extensions and the cr lf framing produce no result
// a byte taken into the input register is parsed from there and its result
// is presented from the result register
// throughput: one byte per cycle while results are taken, set by the single
// parse step between the input register and the result register; the chunk
// counter updates in the same step, so bytes follow back to back
// stall: while a result waits on i_ready the input register still fills once,
// then o_ready drops until the result is taken; nothing is lost
// after completion or an error bytes are swallowed until i_body_start
// reset: synchronous, active low; parser goes to the size line with zero count
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder #(
    parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input byte transaction
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_body_start,
    // result transaction
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_data_byte
);
    import hcbd_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    fire;
    t_result res;

    assign in_item = '{start: i_body_start, data: i_in_byte};

    // the held byte is parsed once the result slot is free or being drained
    assign fire = held_valid && (!o_valid || i_ready);

    hcbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // chunk state and the one-byte parse step
    hcbd_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (held_item),
        .o_res   (res)
    );

    hcbd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res       (res),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte)
    );

endmodule

`default_nettype wire

// ===== rtl/hcbd_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcbd_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hcbd_pkg::t_item i_item,
    input  wire logic           i_take,
    output logic                o_valid,
    output hcbd_pkg::t_item     o_item
);
    import hcbd_pkg::*;

    logic  r_valid;
    t_item r_item;

    // open when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hcbd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hcbd_parser #(
    parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire hcbd_pkg::t_item i_item,
    output hcbd_pkg::t_result    o_res
);
    import hcbd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_remaining, n_remaining;
    logic                   r_digit_seen, n_digit_seen;

    t_phase                 eff_phase;
    logic [COUNT_WIDTH-1:0] eff_remaining;
    logic                   eff_digit_seen;
    t_hex                   hex;
    logic                   size_ovf;
    logic                   is_blank;

    // a start flag restarts the size line before this byte is parsed
    assign eff_phase      = i_item.start ? PH_SIZE : r_phase;
    assign eff_remaining  = i_item.start ? '0 : r_remaining;
    assign eff_digit_seen = i_item.start ? 1'b0 : r_digit_seen;
    assign hex            = hex_decode(i_item.data);
    assign size_ovf       = |eff_remaining[COUNT_WIDTH-1 -: HEX_BITS];
    assign is_blank       = (i_item.data == CH_SP) || (i_item.data == CH_TAB);

    // next state
    always_comb begin
        n_phase      = eff_phase;
        n_remaining  = eff_remaining;
        n_digit_seen = eff_digit_seen;
        unique case (eff_phase)
            PH_SIZE: begin
                if (hex.ok) begin
                    if (size_ovf) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_remaining  = {eff_remaining[COUNT_WIDTH-HEX_BITS-1:0], hex.val};
                        n_digit_seen = 1'b1;
                    end
                end else if (is_blank) begin
                    if (eff_digit_seen) begin
                        n_phase = PH_EXT;
                    end
                end else if (!eff_digit_seen || i_item.data == CH_LF) begin
                    n_phase = PH_DONE;
                end else if (i_item.data == CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end else begin
                    n_phase = PH_EXT;
                end
            end
            PH_EXT: begin
                if (i_item.data == CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end else if (i_item.data == CH_LF) begin
                    n_phase = PH_DONE;
                end
            end
            PH_SIZE_LF: begin
                n_phase = PH_DONE;
                if (i_item.data == CH_LF && eff_remaining != '0) begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_remaining = eff_remaining - COUNT_WIDTH'(1);
                if (eff_remaining == COUNT_WIDTH'(1)) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (i_item.data != CH_CR) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                if (i_item.data != CH_LF) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase      = PH_SIZE;
                    n_remaining  = '0;
                    n_digit_seen = 1'b0;
                end
            end
            default: begin
                // finished: bytes are dropped until a start flag
                n_phase = eff_phase;
            end
        endcase
    end

    // result of this byte
    always_comb begin
        o_res = '{valid: 1'b0, kind: KIND_DATA, data: 8'h00};
        unique case (eff_phase)
            PH_SIZE: begin
                if (hex.ok) begin
                    if (size_ovf) begin
                        o_res = '{valid: 1'b1, kind: KIND_ERR, data: 8'h00};
                    end
                end else if (!is_blank && (!eff_digit_seen || i_item.data == CH_LF)) begin
                    o_res = '{valid: 1'b1, kind: KIND_ERR, data: 8'h00};
                end
            end
            PH_EXT: begin
                if (i_item.data == CH_LF) begin
                    o_res = '{valid: 1'b1, kind: KIND_ERR, data: 8'h00};
                end
            end
            PH_SIZE_LF: begin
                if (i_item.data != CH_LF) begin
                    o_res = '{valid: 1'b1, kind: KIND_ERR, data: 8'h00};
                end else if (eff_remaining == '0) begin
                    o_res = '{valid: 1'b1, kind: KIND_DONE, data: 8'h00};
                end
            end
            PH_DATA: begin
                o_res = '{valid: 1'b1, kind: KIND_DATA, data: i_item.data};
            end
            PH_DATA_CR: begin
                if (i_item.data != CH_CR) begin
                    o_res = '{valid: 1'b1, kind: KIND_ERR, data: 8'h00};
                end
            end
            PH_DATA_LF: begin
                if (i_item.data != CH_LF) begin
                    o_res = '{valid: 1'b1, kind: KIND_ERR, data: 8'h00};
                end
            end
            default: begin
                // finished: no result
                o_res = '{valid: 1'b0, kind: KIND_DATA, data: 8'h00};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SIZE;
            r_remaining  <= '0;
            r_digit_seen <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_remaining  <= n_remaining;
            r_digit_seen <= n_digit_seen;
        end
    end

    `HCBD_ASSERT(a_data_count_live, i_clk, i_rst_n,
        (r_phase == PH_DATA) |-> (r_remaining != '0))
    `HCBD_ASSERT(a_done_silent, i_clk, i_rst_n,
        (i_fire && !i_item.start && r_phase == PH_DONE) |-> !o_res.valid)
    `HCBD_ASSERT_NEXT(a_last_data_byte, i_clk, i_rst_n,
        i_fire && !i_item.start && r_phase == PH_DATA && r_remaining == COUNT_WIDTH'(1),
        r_phase == PH_DATA_CR)

endmodule

`default_nettype wire

// ===== rtl/hcbd_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hcbd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire hcbd_pkg::t_result i_res,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output logic [1:0]             o_kind,
    output logic [7:0]             o_data_byte
);
    import hcbd_pkg::*;

    logic  r_valid;
    t_kind r_kind;
    logic [7:0] r_data;

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_data_byte = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_kind <= i_res.kind;
            r_data <= i_res.data;
        end
    end

    `HCBD_ASSERT(a_data_zero, i_clk, i_rst_n,
        (r_valid && r_kind != KIND_DATA) |-> (r_data == 8'h00))
    `HCBD_ASSERT(a_no_overwrite, i_clk, i_rst_n,
        (r_valid && !i_ready) |-> !i_load)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import hcbd_pkg::*;

    localparam int CW          = COUNT_WIDTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_BYTES  = 1400;

    // expected result of one body byte
    typedef struct {
        t_kind      kind;
        logic [7:0] data;
    } t_expect;

    // clock, reset and the block's inputs, all known from time zero
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_body_start = 1'b0;
    logic       i_ready      = 1'b0;

    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;

    http_chunked_body_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_body_start(i_body_start),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte)
    );

    // 4 ns period
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // body bytes waiting to be driven, results waiting to arrive
    t_item   byte_q[$];
    t_expect want_q[$];

    int unsigned err_count    = 0;
    int unsigned n_in_acc     = 0;
    int unsigned n_out_acc    = 0;
    int unsigned n_gen        = 0;
    int unsigned stall_cycles = 0;
    logic        start_next   = 1'b0;

    // parser copy kept by the testbench
    t_phase      pr_phase = PH_SIZE;
    logic [CW-1:0] pr_left = '0;
    logic        pr_digit = 1'b0;
    logic        pr_last  = 1'b0;

    t_item   drv_item;
    t_expect head;

    // ------------------------------------------------------------------
    // chunked body parser prediction
    // ------------------------------------------------------------------

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - 8'h30);
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - 8'h61 + 8'd10);
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - 8'h41 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void new_size_line();
        pr_phase = PH_SIZE;
        pr_left  = '0;
        pr_digit = 1'b0;
    endfunction

    // framing error ends the body
    function automatic void frame_error();
        pr_phase = PH_DONE;
        want_q.push_back('{kind: KIND_ERR, data: 8'h00});
    endfunction

    // one accepted byte: advance the parser, queue what it yields
    function automatic void predict_byte(input logic [7:0] c, input logic restart);
        logic [3:0] nib;
        logic       is_hex;
        if (restart) begin
            new_size_line();
            pr_last = 1'b0;
        end
        is_hex = hex_nibble(c, nib);
        case (pr_phase)
            PH_SIZE: begin
                if (is_hex) begin
                    // a further digit would not fit the counter
                    if (pr_left[CW-1 -: 4] != 4'h0) begin
                        frame_error();
                    end else begin
                        pr_left  = {pr_left[CW-5:0], nib};
                        pr_digit = 1'b1;
                    end
                end else if (c == CH_SP || c == CH_TAB) begin
                    if (pr_digit) pr_phase = PH_EXT;
                end else if (!pr_digit || c == CH_LF) begin
                    frame_error();
                end else if (c == CH_CR) begin
                    pr_phase = PH_SIZE_LF;
                end else begin
                    pr_phase = PH_EXT;
                end
            end
            PH_EXT: begin
                if (c == CH_CR) begin
                    pr_phase = PH_SIZE_LF;
                end else if (c == CH_LF) begin
                    frame_error();
                end
            end
            PH_SIZE_LF: begin
                if (c != CH_LF) begin
                    frame_error();
                end else if (pr_left == '0) begin
                    pr_last  = 1'b1;
                    pr_phase = PH_DONE;
                    want_q.push_back('{kind: KIND_DONE, data: 8'h00});
                end else begin
                    pr_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                pr_left = pr_left - 1'b1;
                if (pr_left == '0) pr_phase = PH_DATA_CR;
                want_q.push_back('{kind: KIND_DATA, data: c});
            end
            PH_DATA_CR: begin
                if (c != CH_CR) frame_error();
                else pr_phase = PH_DATA_LF;
            end
            PH_DATA_LF: begin
                if (c != CH_LF) frame_error();
                else new_size_line();
            end
            default: begin
                // finished: swallowed until a restart
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [7:0] seen,
                                 input logic [7:0] wanted);
        $display("mismatch at result %0d: %s got 'h%0h want 'h%0h",
                 n_out_acc, what, seen, wanted);
        err_count++;
    endtask

    // random idle cycles, with none in a stretch in the middle of the run
    function automatic logic idle_now();
        if (n_in_acc >= 400 && n_in_acc < 700) return 1'b0;
        return $urandom_range(0, 99) < 10;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    // the first byte of a body carries the restart flag
    task automatic add_byte(input logic [7:0] b);
        byte_q.push_back('{start: start_next, data: b});
        start_next = 1'b0;
        n_gen++;
    endtask

    // bytes after a body, swallowed by the block once the body has ended
    task automatic add_noise();
        repeat ($urandom_range(0, 2)) begin
            byte_q.push_back('{start: 1'b0, data: 8'($urandom_range(0, 255))});
        end
    endtask

    task automatic add_hex(input logic [3:0] nib);
        if (nib < 4'd10) add_byte(8'h30 + 8'(nib));
        else if ($urandom_range(0, 1) != 0) add_byte(8'h61 + 8'(nib) - 8'd10);
        else add_byte(8'h41 + 8'(nib) - 8'd10);
    endtask

    task automatic add_ws();
        if ($urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 2)) begin
                add_byte(($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB);
            end
        end
    endtask

    function automatic logic [7:0] byte_not(input logic [7:0] avoid);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if (r == avoid) r = "Y";
        return r;
    endfunction

    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 8);
        if (r < 99) return $urandom_range(9, 40);
        return $urandom_range(100, 160);
    endfunction

    // spaces, hex size, optional extension, no line end
    task automatic add_size_head(input int unsigned sz);
        int unsigned nd;
        logic [7:0]  c;
        add_ws();
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) add_byte("0");
        end
        nd = 1;
        while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
        for (int i = int'(nd) - 1; i >= 0; i--) add_hex(4'(sz >> (4 * i)));
        if ($urandom_range(0, 99) < 30) begin
            case ($urandom_range(0, 2))
                0: add_byte(CH_SP);
                1: add_byte(CH_TAB);
                default: add_byte(";");
            endcase
            repeat ($urandom_range(0, 4)) begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_CR || c == CH_LF) c = "x";
                add_byte(c);
            end
        end
    endtask

    task automatic add_size_line(input int unsigned sz);
        add_size_head(sz);
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic add_payload(input int unsigned n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    // one body: mostly well formed, the rest broken in one way
    task automatic gen_body();
        int unsigned sz;
        logic [7:0]  c;
        logic [3:0]  nib;
        start_next = 1'b1;
        if ($urandom_range(0, 99) < 80) begin
            repeat ($urandom_range(0, 3)) begin
                sz = pick_size();
                add_size_line(sz);
                add_payload(sz);
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
            add_size_line(0);
        end else begin
            case ($urandom_range(0, 7))
                0: begin
                    // random garbage
                    repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
                end
                1: begin
                    // size line without digits
                    add_ws();
                    case ($urandom_range(0, 3))
                        0: add_byte(CH_CR);
                        1: add_byte(CH_LF);
                        2: add_byte(";");
                        default: begin
                            c = 8'($urandom_range(0, 255));
                            if (hex_nibble(c, nib) || c == CH_SP || c == CH_TAB) c = "g";
                            add_byte(c);
                        end
                    endcase
                end
                2: begin
                    // size too big for the counter
                    add_byte("1");
                    repeat ($urandom_range(8, 10)) add_hex(4'($urandom_range(0, 15)));
                end
                3: begin
                    // bare lf ends the size line
                    add_size_head(pick_size());
                    add_byte(CH_LF);
                end
                4: begin
                    // cr not followed by lf
                    add_size_head(pick_size());
                    add_byte(CH_CR);
                    add_byte(byte_not(CH_LF));
                end
                5: begin
                    // no cr after payload
                    sz = pick_size();
                    add_size_line(sz);
                    add_payload(sz);
                    add_byte(byte_not(CH_CR));
                end
                6: begin
                    // no lf after payload cr
                    sz = pick_size();
                    add_size_line(sz);
                    add_payload(sz);
                    add_byte(CH_CR);
                    add_byte(byte_not(CH_LF));
                end
                default: begin
                    // cut off mid chunk, next body restarts the parser
                    sz = $urandom_range(2, 12);
                    add_size_line(sz);
                    add_payload($urandom_range(0, sz - 1));
                end
            endcase
        end
        add_noise();
    endtask

    // ------------------------------------------------------------------
    // input driver: one byte transaction per accepted edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // transaction taken at this edge, predict what it yields
            if (i_valid && o_ready) begin
                predict_byte(i_in_byte, i_body_start);
                n_in_acc++;
            end
            // payload only moves once the previous one is gone
            if (!i_valid || o_ready) begin
                if (byte_q.size() != 0 && !idle_now()) begin
                    drv_item = byte_q.pop_front();
                    i_valid      <= 1'b1;
                    i_in_byte    <= drv_item.data;
                    i_body_start <= drv_item.start;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: compare each result transaction with the oldest one due
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (want_q.size() == 0) begin
                    flag_mismatch("unexpected result, kind", 8'(o_kind), 8'h00);
                end else begin
                    head = want_q.pop_front();
                    if (o_kind !== 2'(head.kind)) begin
                        flag_mismatch("kind", 8'(o_kind), 8'(head.kind));
                    end
                    if (o_data_byte !== head.data) begin
                        flag_mismatch("data_byte", o_data_byte, head.data);
                    end
                end
                n_out_acc++;
            end
            i_ready <= !idle_now();
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction on either side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        // directed: leading space and tab, extension, extreme payload, final chunk
        start_next = 1'b1;
        add_byte(CH_SP);
        add_byte(CH_TAB);
        add_byte("1");
        add_byte(";");
        add_byte("x");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(8'hFF);
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte("0");
        add_byte(CH_CR);
        add_byte(CH_LF);
        // size line without digits, then a byte swallowed after the error
        start_next = 1'b1;
        add_byte(CH_CR);
        add_byte("7");
        // bare lf on the size line
        start_next = 1'b1;
        add_byte("F");
        add_byte(CH_LF);
        // missing lf after the size line cr
        start_next = 1'b1;
        add_byte("1");
        add_byte(CH_CR);
        add_byte("X");
        // missing cr after payload, zero payload byte
        start_next = 1'b1;
        add_byte("1");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(8'h00);
        add_byte("X");

        // random bodies
        n_gen = 0;
        while (n_gen < RAND_BYTES) gen_body();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all bytes taken and every result back
        while (byte_q.size() != 0 || i_valid || want_q.size() != 0) @(posedge i_clk);
        // let the pipeline drain and catch stray results
        repeat (8) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
